// ===== sv/fmc_pkg.sv =====
// Shared types and constants for the mutex coordinator.
// Used by fmc_front, fmc_back, fifo_mutex_coordinator and the testbench; depends on nothing.
`default_nettype none

package fmc_pkg;

    localparam int ID_W     = 48;
    localparam int TAG_W    = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 3;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_CLOSE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INIT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ENTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEAVE = 3'd3;

    localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INIT    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ENTERED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEFT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_WAIT    = 3'd4;

    typedef enum logic [1:0] {
        OP_CLOSE,
        OP_INIT,
        OP_ENTER,
        OP_LEAVE
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [ID_W-1:0]  id;
        logic [TAG_W-1:0] tag;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_GRANT
    } back_state_t;

endpackage

`default_nettype wire

// ===== sv/fmc_front.sv =====
// Request front end: accepts words, drops unknown modes and queues commands.
// Depends on fmc_pkg; feeds fmc_back through a two-entry command queue.
`default_nettype none

module fmc_front
    import fmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [ID_W-1:0]   client_id,
    input  wire logic [TAG_W-1:0]  echo_tag,
    output logic                   cmd_valid,
    output cmd_t                   cmd,
    input  wire logic              cmd_pop
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       known;
    op_t        op;
    logic       push;

    always_comb
    begin
        known = 1'b1;
        op    = OP_CLOSE;
        case (mode)
            MODE_CLOSE: op = OP_CLOSE;
            MODE_INIT:  op = OP_INIT;
            MODE_ENTER: op = OP_ENTER;
            MODE_LEAVE: op = OP_LEAVE;
            default:    known = 1'b0;
        endcase
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall && known;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{op: op, id: client_id, tag: echo_tag};
        end
    end

`ifndef SYNTHESIS
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("command queue count out of range");
    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !known && !cmd_pop) |=> $stable(count_reg))
        else $error("unknown mode reached the command queue");
`endif

endmodule

`default_nettype wire

// ===== sv/fmc_back.sv =====
// Lock executor: owns the lock state, the wait queue memory and the result register.
// Depends on fmc_pkg; takes commands from fmc_front.
`default_nettype none

module fmc_back
    import fmc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire cmd_t                cmd,
    output logic                     cmd_pop,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [ID_W-1:0]          dest_client,
    output logic [STATUS_W-1:0]      reply_status,
    output logic [TAG_W-1:0]         reply_tag,
    output logic                     queue_overflow,
    output logic                     last
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ID_W-1:0]     queue_mem [QUEUE_DEPTH];
    logic [ID_W-1:0]     rd_data_reg;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic                busy_reg;
    logic                busy_next;
    logic [ID_W-1:0]     owner_reg;
    logic [ID_W-1:0]     owner_next;
    logic [PTR_W-1:0]    head_reg;
    logic [PTR_W-1:0]    head_next;
    logic [PTR_W-1:0]    tail_reg;
    logic [PTR_W-1:0]    tail_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [TAG_W-1:0]    hold_tag_reg;
    logic [TAG_W-1:0]    hold_tag_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [ID_W-1:0]     dest_reg;
    logic [ID_W-1:0]     dest_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    tag_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                last_reg;
    logic                last_next;

    logic                out_free;
    logic                wr_en;
    logic                rd_en;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        owner_next     = owner_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        hold_tag_next  = hold_tag_reg;
        out_valid_next = out_valid_reg && out_stall;
        dest_next      = dest_reg;
        status_next    = status_reg;
        tag_next       = tag_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop   = 1'b1;
                    dest_next = cmd.id;
                    tag_next  = cmd.tag;
                    ovf_next  = 1'b0;
                    last_next = 1'b1;
                    case (cmd.op)
                        OP_CLOSE:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_CLOSED;
                        end
                        OP_INIT:
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_INIT;
                        end
                        OP_ENTER:
                        begin
                            out_valid_next = 1'b1;
                            if (!busy_reg)
                            begin
                                busy_next   = 1'b1;
                                owner_next  = cmd.id;
                                status_next = ST_ENTERED;
                            end
                            else if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                status_next = ST_WAIT;
                                ovf_next    = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_WAIT;
                                wr_en       = 1'b1;
                                count_next  = count_reg + 1'b1;
                                tail_next   = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                              '0 : tail_reg + 1'b1;
                            end
                        end
                        OP_LEAVE:
                        begin
                            if (busy_reg && owner_reg == cmd.id)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = ST_LEFT;
                                if (count_reg == '0)
                                begin
                                    busy_next = 1'b0;
                                end
                                else
                                begin
                                    last_next     = 1'b0;
                                    rd_en         = 1'b1;
                                    hold_tag_next = cmd.tag;
                                    count_next    = count_reg - 1'b1;
                                    head_next     = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                    '0 : head_reg + 1'b1;
                                    state_next    = BK_GRANT;
                                end
                            end
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && out_stall;
                        end
                    endcase
                end
            end
            BK_GRANT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    dest_next      = rd_data_reg;
                    status_next    = ST_ENTERED;
                    tag_next       = hold_tag_reg;
                    ovf_next       = 1'b0;
                    last_next      = 1'b1;
                    owner_next     = rd_data_reg;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            busy_reg      <= 1'b0;
            owner_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            owner_reg     <= owner_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_tag_reg <= hold_tag_next;
        dest_reg     <= dest_next;
        status_reg   <= status_next;
        tag_reg      <= tag_next;
        ovf_reg      <= ovf_next;
        last_reg     <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[tail_reg] <= cmd.id;
        end
        if (rd_en)
        begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    assign out_valid      = out_valid_reg;
    assign dest_client    = dest_reg;
    assign reply_status   = status_reg;
    assign reply_tag      = tag_reg;
    assign queue_overflow = ovf_reg;
    assign last           = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("wait queue count exceeds its depth");
    a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_GRANT) |-> busy_reg)
        else $error("handoff pending while the lock is free");
    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (state_reg == BK_GRANT))
        else $error("first result of a leave without a pending handoff");
    a_ovf_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> (status_reg == ST_WAIT && count_reg != '0))
        else $error("overflow flagged on a result that is not a wait");
`endif

endmodule

`default_nettype wire

// ===== sv/fifo_mutex_coordinator.sv =====
// Top level of the mutex coordinator: front end, command queue and lock executor.
// Depends on fmc_pkg, fmc_front and fmc_back.
//
// Each input word is a lock request; unknown modes are accepted and give no result.
// The executor finishes one request per cycle while its output register is free, and a leave
// that hands the lock to a waiting client gives two results, since both results pass through
// the one output register; the second result, issued from the grant state, also covers
// the registered read of the wait-queue memory. A request passes through a two-entry
// command queue before the executor, and each result sits in an output register, so up
// to two further words are accepted while a result stalls.
// An enter against a full wait queue answers wait with queue_overflow set.
`default_nettype none

module fifo_mutex_coordinator
    import fmc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [ID_W-1:0]     client_id,
    input  wire logic [TAG_W-1:0]    echo_tag,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [ID_W-1:0]          dest_client,
    output logic [STATUS_W-1:0]      reply_status,
    output logic [TAG_W-1:0]         reply_tag,
    output logic                     queue_overflow,
    output logic                     last
);

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;

    fmc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .client_id (client_id),
        .echo_tag  (echo_tag),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    fmc_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dest_client    (dest_client),
        .reply_status   (reply_status),
        .reply_tag      (reply_tag),
        .queue_overflow (queue_overflow),
        .last           (last)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fifo_mutex_coordinator: a short list of directed lock requests,
// then random request sequences, each reply compared against a model of the lock and queue.
// Depends on fmc_pkg and the coordinator RTL.
module testbench;
    import fmc_pkg::*;

    localparam int ITEMS        = 1150;
    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int WQ_W         = $clog2(DEPTH);
    localparam int MAX_REPORTS  = 10;
    localparam int SETTLE_CYCLES = 20;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int NUM_ROWS     = 23;

    localparam logic [MODE_W-1:0] MODE_RSVD4 = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RSVD5 = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam logic [ID_W-1:0]  ID_ZERO  = '0;
    localparam logic [ID_W-1:0]  ID_ALL   = '1;
    localparam logic [ID_W-1:0]  CLIENT_A = 48'hC0A8_0001_1F90;
    localparam logic [ID_W-1:0]  CLIENT_B = 48'h0A00_0002_0050;
    localparam logic [TAG_W-1:0] TAG_ZERO = '0;
    localparam logic [TAG_W-1:0] TAG_ALL  = '1;

    typedef struct packed {
        logic [ID_W-1:0]     dest;
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag;
        logic                ovf;
        logic                fin;
    } reply_t;

    typedef struct {
        logic [MODE_W-1:0]   m;
        logic [ID_W-1:0]     id;
        logic [TAG_W-1:0]    tag;
        bit                  typed;
        logic [STATUS_W-1:0] st;
        logic                ovf;
    } row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic [MODE_W-1:0]   mode      = '0;
    logic [ID_W-1:0]     client_id = '0;
    logic [TAG_W-1:0]    echo_tag  = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    logic [ID_W-1:0]     dest_client;
    logic [STATUS_W-1:0] reply_status;
    logic [TAG_W-1:0]    reply_tag;
    logic                queue_overflow;
    logic                last;

    bit idle_in  = 1'b1;
    bit idle_out = 1'b1;

    bit              lock_held;
    logic [ID_W-1:0] lock_owner;
    logic [ID_W-1:0] waiters [DEPTH];
    int              wq_head;
    int              wq_tail;
    int              wq_count;

    reply_t pending_replies [$];
    row_t   script [NUM_ROWS];

    int n_requests;
    int n_replies;
    int n_handoffs;
    int n_overflows;
    int n_fail;

    fifo_mutex_coordinator DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .client_id      (client_id),
        .echo_tag       (echo_tag),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .dest_client    (dest_client),
        .reply_status   (reply_status),
        .reply_tag      (reply_tag),
        .queue_overflow (queue_overflow),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("Timeout with %0d replies still outstanding.", pending_replies.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic void note_failure(input string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endfunction

    function automatic void expect_reply(input logic [ID_W-1:0] dest,
                                         input logic [STATUS_W-1:0] status,
                                         input logic [TAG_W-1:0] tag,
                                         input logic ovf, input logic fin);
        reply_t r;
        r.dest   = dest;
        r.status = status;
        r.tag    = tag;
        r.ovf    = ovf;
        r.fin    = fin;
        pending_replies.push_back(r);
    endfunction

    function automatic void predict_replies(input logic [MODE_W-1:0] m,
                                            input logic [ID_W-1:0] id,
                                            input logic [TAG_W-1:0] tag);
        case (m)
            MODE_CLOSE: expect_reply(id, ST_CLOSED, tag, 1'b0, 1'b1);
            MODE_INIT:  expect_reply(id, ST_INIT, tag, 1'b0, 1'b1);
            MODE_ENTER:
            begin
                if (!lock_held)
                begin
                    lock_held  = 1'b1;
                    lock_owner = id;
                    expect_reply(id, ST_ENTERED, tag, 1'b0, 1'b1);
                end
                else if (wq_count >= DEPTH)
                begin
                    n_overflows++;
                    expect_reply(id, ST_WAIT, tag, 1'b1, 1'b1);
                end
                else
                begin
                    waiters[WQ_W'(wq_tail)] = id;
                    wq_tail = (wq_tail + 1) % DEPTH;
                    wq_count++;
                    expect_reply(id, ST_WAIT, tag, 1'b0, 1'b1);
                end
            end
            MODE_LEAVE:
            begin
                if (lock_held && lock_owner == id)
                begin
                    if (wq_count == 0)
                    begin
                        lock_held = 1'b0;
                        expect_reply(id, ST_LEFT, tag, 1'b0, 1'b1);
                    end
                    else
                    begin
                        expect_reply(id, ST_LEFT, tag, 1'b0, 1'b0);
                        lock_owner = waiters[WQ_W'(wq_head)];
                        wq_head = (wq_head + 1) % DEPTH;
                        wq_count--;
                        n_handoffs++;
                        expect_reply(lock_owner, ST_ENTERED, tag, 1'b0, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_reply();
        reply_t want;
        if (pending_replies.size() == 0)
        begin
            note_failure($sformatf("unexpected reply: dest %h status %0d tag %h ovf %b last %b",
                                   dest_client, reply_status, reply_tag, queue_overflow, last));
            return;
        end
        want = pending_replies.pop_front();
        if (dest_client !== want.dest || reply_status !== want.status ||
            reply_tag !== want.tag || queue_overflow !== want.ovf || last !== want.fin)
            note_failure($sformatf({"reply %0d: expected dest %h status %0d tag %h ovf %b last %b,",
                                    " got dest %h status %0d tag %h ovf %b last %b"},
                                   n_replies, want.dest, want.status, want.tag, want.ovf,
                                   want.fin, dest_client, reply_status, reply_tag,
                                   queue_overflow, last));
        n_replies++;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ID_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_request(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                                input logic [TAG_W-1:0] tag, output int n_new,
                                output reply_t first);
        int gap;
        int base;
        gap = idle_in ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        client_id <= id;
        echo_tag  <= tag;
        do
            @(posedge clk);
        while (in_stall);
        base = pending_replies.size();
        predict_replies(m, id, tag);
        n_new = pending_replies.size() - base;
        first = (n_new > 0) ? pending_replies[base] : '0;
        n_requests++;
        @(negedge clk);
    endtask

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                check_reply();
                hold = idle_out ? $urandom_range(0, 4) : 0;
            end
            @(negedge clk);
            out_stall <= (hold > 0);
            if (hold > 0)
                hold--;
        end
    end

    initial
    begin
        int              n_new;
        reply_t          first;
        int              burst;
        int              pick;
        logic [ID_W-1:0] pool [4];

        lock_held  = 1'b0;
        lock_owner = '0;
        wq_head    = 0;
        wq_tail    = 0;
        wq_count   = 0;

        script = '{
            '{MODE_CLOSE, ID_ZERO,  TAG_ZERO,     1'b1, ST_CLOSED,  1'b0},
            '{MODE_INIT,  ID_ALL,   TAG_ALL,      1'b1, ST_INIT,    1'b0},
            '{MODE_LEAVE, CLIENT_A, 32'h0000_0001, 1'b0, '0,         1'b0},
            '{MODE_ENTER, CLIENT_A, 32'h0000_0010, 1'b1, ST_ENTERED, 1'b0},
            '{MODE_ENTER, CLIENT_A, 32'h0000_0011, 1'b1, ST_WAIT,    1'b0},
            '{MODE_ENTER, CLIENT_B, 32'h0000_0012, 1'b1, ST_WAIT,    1'b0},
            '{MODE_ENTER, CLIENT_B, 32'h0000_0013, 1'b0, '0,         1'b0},
            '{MODE_LEAVE, CLIENT_B, 32'h0000_0014, 1'b0, '0,         1'b0},
            '{MODE_RSVD4, CLIENT_A, 32'h0000_0015, 1'b0, '0,         1'b0},
            '{MODE_RSVD7, ID_ALL,   TAG_ALL,      1'b0, '0,         1'b0},
            '{MODE_LEAVE, CLIENT_A, 32'h0000_0016, 1'b1, ST_LEFT,    1'b0},
            '{MODE_LEAVE, CLIENT_A, 32'h0000_0017, 1'b0, '0,         1'b0},
            '{MODE_CLOSE, CLIENT_B, 32'h0000_0018, 1'b1, ST_CLOSED,  1'b0},
            '{MODE_ENTER, ID_ALL,   TAG_ALL,      1'b1, ST_WAIT,    1'b0},
            '{MODE_LEAVE, CLIENT_B, 32'h0000_0019, 1'b0, '0,         1'b0},
            '{MODE_LEAVE, CLIENT_B, 32'h0000_001A, 1'b0, '0,         1'b0},
            '{MODE_LEAVE, ID_ALL,   TAG_ZERO,     1'b0, '0,         1'b0},
            '{MODE_ENTER, ID_ZERO,  TAG_ALL,      1'b1, ST_ENTERED, 1'b0},
            '{MODE_LEAVE, ID_ALL,   32'h0000_001B, 1'b0, '0,         1'b0},
            '{MODE_RSVD5, ID_ZERO,  32'h0000_001C, 1'b0, '0,         1'b0},
            '{MODE_RSVD6, CLIENT_B, 32'h0000_001D, 1'b0, '0,         1'b0},
            '{MODE_LEAVE, ID_ZERO,  32'h0000_001E, 1'b0, '0,         1'b0},
            '{MODE_INIT,  CLIENT_B, 32'h0000_001F, 1'b1, ST_INIT,    1'b0}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
        begin
            send_request(script[i].m, script[i].id, script[i].tag, n_new, first);
            if (script[i].typed && (n_new == 0 || first.dest !== script[i].id ||
                first.status !== script[i].st || first.ovf !== script[i].ovf))
                note_failure($sformatf({"directed word %0d: expected dest %h status %0d",
                                        " ovf %b, got dest %h status %0d ovf %b"},
                                       i, script[i].id, script[i].st, script[i].ovf,
                                       first.dest, first.status, first.ovf));
        end

        // Fill bursts can push the wait queue past full; mixed runs keep the owner handing off.
        while (n_requests < ITEMS)
        begin
            idle_in  = ($urandom_range(0, 3) != 0);
            idle_out = ($urandom_range(0, 3) != 0);
            foreach (pool[k])
                pool[k] = rand_id();
            if ($urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(14, 22);
                repeat (burst)
                    send_request(MODE_ENTER, pool[2'($urandom_range(0, 3))], $urandom,
                                 n_new, first);
                while (lock_held)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_request(MODE_W'($urandom_range(MODE_CLOSE, MODE_RSVD7)),
                                     rand_id(), $urandom, n_new, first);
                    else
                        send_request(MODE_LEAVE, lock_owner, $urandom, n_new, first);
                end
            end
            else
            begin
                repeat (24)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 7)
                        send_request(MODE_ENTER, pool[2'($urandom_range(0, 3))], $urandom,
                                     n_new, first);
                    else if (pick < 13)
                        send_request(MODE_LEAVE, lock_owner, $urandom, n_new, first);
                    else if (pick < 15)
                        send_request(MODE_LEAVE, pool[2'($urandom_range(0, 3))], $urandom,
                                     n_new, first);
                    else if (pick < 17)
                        send_request(($urandom_range(0, 1) != 0) ? MODE_INIT : MODE_CLOSE,
                                     rand_id(), $urandom, n_new, first);
                    else
                        send_request(MODE_W'($urandom_range(MODE_RSVD4, MODE_RSVD7)),
                                     rand_id(), $urandom, n_new, first);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d lock requests and %0d checked replies,", n_requests, n_replies);
        $display("including %0d queue handoffs and %0d full-queue rejections.",
                 n_handoffs, n_overflows);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
